>>> design/tcpc_pkg.sv
// Shared types and constants of the text cell priority compositor.
package tcpc_pkg;

  localparam int GLYPH_W     = 8;
  localparam int COLOR_W     = 16;
  localparam int ORDER_W     = 16;
  localparam int COORD_W     = 12;
  localparam int COLS_REG_W  = 8;
  localparam int ROWS_REG_W  = 7;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam int COLS_RESET = 80;
  localparam int ROWS_RESET = 25;

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'h20;
  localparam logic [COLOR_W-1:0] BLANK_COLOR = 16'h0000;
  localparam logic [ORDER_W-1:0] EMPTY_ORDER = 16'hFFFF;

  typedef enum logic [IN_TUSER_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_COLS = 1'b0,
    REG_SCREEN_ROWS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_RUN,
    ST_SWEEP
  } eng_state_t;

  // glyph sits in the lowest bits
  typedef struct packed {
    logic signed [ORDER_W-1:0] order;
    logic [COLOR_W-1:0]        color;
    logic [GLYPH_W-1:0]        glyph;
  } cell_t;

  typedef struct packed {
    logic      valid;
    req_kind_t kind;
    logic      hit;
    cell_t     data;
  } stage_t;

  typedef struct packed {
    logic advance;
    logic sweeping;
    logic clear_pending;
  } eng_status_t;

  localparam cell_t BLANK_CELL = '{order: EMPTY_ORDER, color: BLANK_COLOR, glyph: BLANK_GLYPH};

endpackage

>>> design/tcpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tcpc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/tcpc_addr_gen.sv
// Request decode, clipping and cell address generation (first pipeline stage).
module tcpc_addr_gen #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  localparam int DEPTH = MAX_COLS * MAX_ROWS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int ECW   = $clog2(MAX_COLS + 1),
  localparam int ERW   = $clog2(MAX_ROWS + 1),
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept_i,
  input  logic                                advance_i,
  input  logic [tcpc_pkg::IN_TDATA_W-1:0]     tdata_i,
  input  logic [tcpc_pkg::IN_TUSER_W-1:0]     tuser_i,
  input  logic [ECW-1:0]                      eff_cols_i,
  input  logic [ERW-1:0]                      eff_rows_i,
  output tcpc_pkg::stage_t                    s1_o,
  output logic [AW-1:0]                       s1_addr_o
);

  logic signed [tcpc_pkg::COORD_W-1:0] pos_x;
  logic signed [tcpc_pkg::COORD_W-1:0] pos_y;
  logic [tcpc_pkg::COORD_W-1:0]        char_offset;
  tcpc_pkg::req_kind_t                 kind;
  logic signed [13:0]                  col;
  logic                                col_ok;
  logic                                row_ok;
  logic [AW-1:0]                       addr;
  tcpc_pkg::stage_t                    s1_nxt;
  tcpc_pkg::stage_t                    s1_r;
  logic [AW-1:0]                       s1_addr_r;

  assign pos_x       = tdata_i[11:0];
  assign pos_y       = tdata_i[23:12];
  assign char_offset = tdata_i[35:24];
  assign kind        = tcpc_pkg::req_kind_t'(tuser_i);

  // draws place the glyph at the string start plus its offset
  always_comb begin
    if (kind == tcpc_pkg::REQ_DRAW) begin
      col = {pos_x[11], pos_x[11], pos_x} + {2'b00, char_offset};
    end else begin
      col = {pos_x[11], pos_x[11], pos_x};
    end
  end

  assign col_ok = !col[13] && (col[12:0] < 13'(eff_cols_i));
  assign row_ok = !pos_y[11] && (pos_y[10:0] < 11'(eff_rows_i));

  // row * cols + col stays below DEPTH, so arithmetic modulo 2^AW is exact
  assign addr = AW'(pos_y[RW-1:0]) * AW'(eff_cols_i) + AW'(col[CW-1:0]);

  always_comb begin
    s1_nxt            = '0;
    s1_nxt.valid      = accept_i;
    s1_nxt.kind       = kind;
    s1_nxt.hit        = col_ok && row_ok;
    s1_nxt.data.glyph = tdata_i[43:36];
    s1_nxt.data.color = tdata_i[59:44];
    s1_nxt.data.order = tdata_i[75:60];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (advance_i) begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_i) begin
      s1_addr_r <= addr;
    end
  end

  assign s1_o      = s1_r;
  assign s1_addr_o = s1_addr_r;

endmodule

>>> design/tcpc_cell_engine.sv
// Cell store read-modify-write with same-address forwarding and the clear sweep.
module tcpc_cell_engine #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  localparam int DEPTH = MAX_COLS * MAX_ROWS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int ECW   = $clog2(MAX_COLS + 1),
  localparam int ERW   = $clog2(MAX_ROWS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcpc_pkg::stage_t      s1_i,
  input  logic [AW-1:0]         s1_addr_i,
  input  logic [ECW-1:0]        eff_cols_i,
  input  logic [ERW-1:0]        eff_rows_i,
  input  logic                  out_busy_i,
  output tcpc_pkg::eng_status_t status_o,
  output logic                  res_valid_o,
  output tcpc_pkg::cell_t       res_cell_o,
  output logic                  res_hit_o
);

  tcpc_pkg::eng_state_t state_r;
  tcpc_pkg::eng_state_t state_nxt;
  tcpc_pkg::stage_t     s2_r;
  logic [AW-1:0]        s2_addr_r;
  logic                 fwd_v_r;
  tcpc_pkg::cell_t      fwd_cell_r;
  logic [AW-1:0]        cnt_r;
  logic [AW:0]          last_r;
  logic [AW:0]          sweep_last;
  tcpc_pkg::cell_t      rd_cell;
  tcpc_pkg::cell_t      old_cell;
  logic                 advance;
  logic                 start_sweep;
  logic                 sweep_done;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  tcpc_pkg::cell_t      wr_cell;

  tcpc_ram #(
    .WIDTH ($bits(tcpc_pkg::cell_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_cell),
    .rd_en   (advance),
    .rd_addr (s1_addr_i),
    .rd_data (rd_cell)
  );

  // write that hit the same entry while it was being read wins over the RAM
  assign old_cell   = fwd_v_r ? fwd_cell_r : rd_cell;
  assign sweep_last = (AW + 1)'(eff_cols_i) * (AW + 1)'(eff_rows_i) - (AW + 1)'(1);
  assign sweep_done = ({1'b0, cnt_r} == last_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcpc_pkg::ST_RUN: begin
        if (start_sweep) begin
          state_nxt = tcpc_pkg::ST_SWEEP;
        end
      end
      tcpc_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = tcpc_pkg::ST_RUN;
        end
      end
      default: state_nxt = tcpc_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    advance     = 1'b0;
    start_sweep = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = s2_addr_r;
    wr_cell     = s2_r.data;
    unique case (state_r)
      tcpc_pkg::ST_RUN: begin
        advance = !(s2_r.valid && (s2_r.kind == tcpc_pkg::REQ_READ) && out_busy_i);
        start_sweep = advance && s2_r.valid && (s2_r.kind == tcpc_pkg::REQ_CLEAR);
        wr_en = advance && s2_r.valid && (s2_r.kind == tcpc_pkg::REQ_DRAW) && s2_r.hit &&
                (old_cell.order <= s2_r.data.order);
      end
      tcpc_pkg::ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_cell = tcpc_pkg::BLANK_CELL;
      end
      default: begin
        advance = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcpc_pkg::ST_SWEEP;
      s2_r    <= '0;
      fwd_v_r <= 1'b0;
      cnt_r   <= '0;
      last_r  <= (AW + 1)'(DEPTH - 1);
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        s2_r    <= s1_i;
        fwd_v_r <= wr_en && (wr_addr == s1_addr_i);
      end
      if (start_sweep) begin
        cnt_r  <= '0;
        last_r <= sweep_last;
      end else if (state_r == tcpc_pkg::ST_SWEEP) begin
        cnt_r <= cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_addr_r  <= s1_addr_i;
      fwd_cell_r <= wr_cell;
    end
  end

  assign res_valid_o = advance && s2_r.valid && (s2_r.kind == tcpc_pkg::REQ_READ);
  assign res_cell_o  = s2_r.hit ? old_cell : '0;
  assign res_hit_o   = s2_r.hit;

  assign status_o.advance       = advance;
  assign status_o.sweeping      = (state_r == tcpc_pkg::ST_SWEEP);
  assign status_o.clear_pending = s2_r.valid && (s2_r.kind == tcpc_pkg::REQ_CLEAR);

endmodule

>>> design/text_cell_priority_compositor_core.sv
// Top level of the text cell priority compositor: ports, configuration and result register.
//
// Character-cell frame compositor with a per-cell priority test. Each input transaction
// carries a request kind in in_tuser (clear frame, draw one glyph, read one cell, the
// fourth code does nothing) and its fields in in_tdata. A draw lands at column
// pos_x + char_offset and row pos_y; positions off the configured screen are dropped, and
// a cell is overwritten only when its stored order is not greater than the new order. A
// read returns one output transaction with the cell contents and in_range set, or all
// zeros with in_range clear when the position is off screen; clears and draws return
// nothing. Draws and reads are taken one per cycle, except while a clear is pending or
// sweeping or a read waits behind a result held at a stalled output. A read passes
// through these registers in order: clipping and the row * cols + col address are
// formed ahead of the accepting edge and registered there, the cell store read data
// is registered next, and the output register loads last. The cell store is one RAM
// with one read and one write port; a draw reads its cell when it leaves the address
// stage and writes it back when it leaves the read stage, and a write that meets a
// read of the same cell at the same edge is forwarded to it. A clear waits for earlier
// requests to finish, then sweeps cells 0 to cols*rows-1 at one cell per cycle, so
// in_tready stays low from the acceptance of the clear until the sweep is over. After
// reset the whole store, MAX_COLS * MAX_ROWS cells (8192 by default), is swept the same
// way, with in_tready low, before the first request is taken. Configuration writes are
// taken at any time but must only be issued while the block is idle; rows come from the
// low 7 bits, zero counts as one and values above MAX_COLS or MAX_ROWS as that maximum.
module text_cell_priority_compositor_core #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, from bit 0: pos_x[12], pos_y[12], char_offset[12], glyph[8], color[16],
  // order[16], zero pad[4]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tcpc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser, from bit 0: req_type[2]
  input  logic [tcpc_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, from bit 0: cell_glyph[8], cell_color[16], cell_order[16]
  output logic [tcpc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser, from bit 0: in_range[1]
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [tcpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tcpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ECW     = $clog2(MAX_COLS + 1);
  localparam int ERW     = $clog2(MAX_ROWS + 1);
  localparam int ColsRst = (tcpc_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : tcpc_pkg::COLS_RESET;
  localparam int RowsRst = (tcpc_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : tcpc_pkg::ROWS_RESET;

  logic [ECW-1:0]                      eff_cols_r;
  logic [ERW-1:0]                      eff_rows_r;
  logic [ECW-1:0]                      eff_cols_nxt;
  logic [ERW-1:0]                      eff_rows_nxt;
  logic [tcpc_pkg::COLS_REG_W-1:0]     cols_raw;
  logic [tcpc_pkg::ROWS_REG_W-1:0]     rows_raw;
  logic                                in_accept;
  tcpc_pkg::stage_t                    s1;
  logic [AW-1:0]                       s1_addr;
  tcpc_pkg::eng_status_t               eng_status;
  logic                                res_valid;
  tcpc_pkg::cell_t                     res_cell;
  logic                                res_hit;
  logic                                out_busy;
  logic                                out_valid_r;
  tcpc_pkg::cell_t                     out_cell_r;
  logic                                out_hit_r;

  // Store the clamped column and row counts so the datapath never sees zero or overflow.
  assign cols_raw = cfg_wdata[tcpc_pkg::COLS_REG_W-1:0];
  assign rows_raw = cfg_wdata[tcpc_pkg::ROWS_REG_W-1:0];

  always_comb begin
    if (cols_raw == '0) begin
      eff_cols_nxt = ECW'(1);
    end else if (int'(cols_raw) > MAX_COLS) begin
      eff_cols_nxt = ECW'(MAX_COLS);
    end else begin
      eff_cols_nxt = ECW'(cols_raw);
    end
    if (rows_raw == '0) begin
      eff_rows_nxt = ERW'(1);
    end else if (int'(rows_raw) > MAX_ROWS) begin
      eff_rows_nxt = ERW'(MAX_ROWS);
    end else begin
      eff_rows_nxt = ERW'(rows_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_cols_r <= ECW'(ColsRst);
      eff_rows_r <= ERW'(RowsRst);
    end else if (cfg_wr_en) begin
      unique case (tcpc_pkg::cfg_reg_t'(cfg_index))
        tcpc_pkg::REG_SCREEN_COLS: eff_cols_r <= eff_cols_nxt;
        tcpc_pkg::REG_SCREEN_ROWS: eff_rows_r <= eff_rows_nxt;
        default: ;
      endcase
    end
  end

  // Hold off new requests while the engine stalls, and behind a clear until its sweep has finished.
  assign in_tready = eng_status.advance && !eng_status.sweeping && !eng_status.clear_pending &&
                     !(s1.valid && (s1.kind == tcpc_pkg::REQ_CLEAR));
  assign in_accept = in_tvalid && in_tready;

  tcpc_addr_gen #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_addr_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept_i   (in_accept),
    .advance_i  (eng_status.advance),
    .tdata_i    (in_tdata),
    .tuser_i    (in_tuser),
    .eff_cols_i (eff_cols_r),
    .eff_rows_i (eff_rows_r),
    .s1_o       (s1),
    .s1_addr_o  (s1_addr)
  );

  tcpc_cell_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cell_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_i        (s1),
    .s1_addr_i   (s1_addr),
    .eff_cols_i  (eff_cols_r),
    .eff_rows_i  (eff_rows_r),
    .out_busy_i  (out_busy),
    .status_o    (eng_status),
    .res_valid_o (res_valid),
    .res_cell_o  (res_cell),
    .res_hit_o   (res_hit)
  );

  // Output register: a read result waits here while draws keep flowing behind it.
  assign out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_cell_r <= res_cell;
      out_hit_r  <= res_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cell_r;
  assign out_tuser  = out_hit_r;

endmodule

>>> design/tcpc_checker.sv
// Port-level checks of the text cell priority compositor, bound to the top level.
module tcpc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [tcpc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tcpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                       out_tuser
);

  // the store sweep after reset blocks requests
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("request accepted right after reset");

  // a clear blocks the input once it is accepted
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == tcpc_pkg::REQ_CLEAR) |=> !in_tready)
    else $error("request accepted behind a clear");

  // an off-screen read returns zero cell fields
  a_off_screen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("off-screen read with nonzero cell data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind text_cell_priority_compositor_core tcpc_checker u_tcpc_checker (.*);

>>> test/tcpc_cell_checker.sv
// Cell read checker for the text cell compositor: tracks the frame store and compares reads.
module tcpc_cell_checker
  import tcpc_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     reads_pending
);

  localparam int CELLS     = MAX_COLS * MAX_ROWS;
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = 12;
  localparam int OFF_LSB   = 24;
  localparam int GLYPH_LSB = 36;
  localparam int COLOR_LSB = 44;
  localparam int ORDER_LSB = 60;

  typedef struct packed {
    logic [GLYPH_W-1:0]        glyph;
    logic [COLOR_W-1:0]        color;
    logic signed [ORDER_W-1:0] order;
    logic                      on_screen;
  } cell_read_t;

  logic [GLYPH_W-1:0]        glyph_mem [CELLS];
  logic [COLOR_W-1:0]        color_mem [CELLS];
  logic signed [ORDER_W-1:0] order_mem [CELLS];
  logic [COLS_REG_W-1:0]     cols_reg;
  logic [ROWS_REG_W-1:0]     rows_reg;
  cell_read_t                expected_cells [$];
  int                        errors = 0;

  // Zero counts as one, anything above the store size is clamped.
  function automatic int used_cols();
    if (cols_reg == 0) return 1;
    if (int'(cols_reg) > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int used_rows();
    if (rows_reg == 0) return 1;
    if (int'(rows_reg) > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  // Cell index of a screen position, -1 when clipped.
  function automatic int cell_index(int col, int row);
    if (row < 0 || row >= used_rows() || col < 0 || col >= used_cols()) return -1;
    return row * used_cols() + col;
  endfunction

  task automatic blank_cells(int count);
    for (int i = 0; i < count && i < CELLS; i++) begin
      glyph_mem[i] = BLANK_GLYPH;
      color_mem[i] = BLANK_COLOR;
      order_mem[i] = EMPTY_ORDER;
    end
  endtask

  task automatic apply_request(req_kind_t kind, logic [IN_TDATA_W-1:0] d);
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        off;
    logic signed [ORDER_W-1:0] ord;
    cell_read_t                rd;
    int                        idx;
    x   = d[X_LSB +: COORD_W];
    y   = d[Y_LSB +: COORD_W];
    off = d[OFF_LSB +: COORD_W];
    ord = d[ORDER_LSB +: ORDER_W];
    case (kind)
      REQ_CLEAR: blank_cells(used_cols() * used_rows());
      REQ_DRAW: begin
        idx = cell_index(int'(x) + int'(off), int'(y));
        if (idx >= 0 && order_mem[idx] <= ord) begin
          glyph_mem[idx] = d[GLYPH_LSB +: GLYPH_W];
          color_mem[idx] = d[COLOR_LSB +: COLOR_W];
          order_mem[idx] = ord;
        end
      end
      REQ_READ: begin
        idx = cell_index(int'(x), int'(y));
        rd  = '0;
        if (idx >= 0) rd = '{glyph_mem[idx], color_mem[idx], order_mem[idx], 1'b1};
        expected_cells.push_back(rd);
      end
      default: ;
    endcase
  endtask

  task automatic check_result(logic [OUT_TDATA_W-1:0] d, logic flag);
    cell_read_t want;
    if (expected_cells.size() == 0) begin
      $error("read result with no read request waiting");
      errors++;
      return;
    end
    want = expected_cells.pop_front();
    if (d[7:0] !== want.glyph) begin
      $error("cell_glyph: expected %0h, got %0h", want.glyph, d[7:0]);
      errors++;
    end
    if (d[23:8] !== want.color) begin
      $error("cell_color: expected %0h, got %0h", want.color, d[23:8]);
      errors++;
    end
    if (d[39:24] !== want.order) begin
      $error("cell_order: expected %0d, got %0d", want.order, $signed(d[39:24]));
      errors++;
    end
    if (flag !== want.on_screen) begin
      $error("in_range: expected %0b, got %0b", want.on_screen, flag);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_reg = COLS_REG_W'(COLS_RESET);
      rows_reg = ROWS_REG_W'(ROWS_RESET);
      blank_cells(CELLS);
      expected_cells.delete();
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata, out_tuser[0]);
      if (in_tvalid && in_tready) apply_request(req_kind_t'(in_tuser), in_tdata);
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCREEN_COLS: cols_reg = cfg_wdata[COLS_REG_W-1:0];
          REG_SCREEN_ROWS: rows_reg = cfg_wdata[ROWS_REG_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count    <= errors;
    reads_pending <= expected_cells.size();
  end

endmodule

>>> test/tb.sv
// Testbench top for the text cell compositor: clock, reset, stimulus and verdict.
module tb;
  import tcpc_pkg::*;

  localparam int MAX_COLS      = 128;
  localparam int MAX_ROWS      = 64;
  // Slowest correct run stays well under this: reset sweep, a few dozen full-screen
  // clears and about 850 transactions with stalls on both sides.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Drain time for the draw/read pipeline once no read result is outstanding.
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int   fail_count;
  int   reads_pending;
  int   cycle_count   = 0;
  int   tx_idle_pct   = 24;
  int   rx_idle_pct   = 55;
  logic rx_hold_req   = 1'b0;
  logic rx_hold_taken = 1'b0;
  int   rx_hold_left  = 0;
  // Effective screen size, used only to aim positions at and around the screen.
  int   screen_w      = COLS_RESET;
  int   screen_h      = ROWS_RESET;
  // Recently drawn positions, so reads hit cells that hold something.
  int   drawn_col [$];
  int   drawn_row [$];

  text_cell_priority_compositor_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tcpc_cell_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .reads_pending (reads_pending)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run as a failure once CYCLE_LIMIT is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off counted here so the
  // pipeline backs up and in_tready drops while the sender keeps offering reads.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready   <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req && !rx_hold_taken) begin
      out_tready    <= 1'b0;
      rx_hold_left  <= LONG_HOLD;
      rx_hold_taken <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one transaction, with random idle cycles ahead of it, and hold it until
  // accepted. tvalid stays high on return so back-to-back transactions need no gap.
  // Field values are taken modulo their field widths.
  task automatic issue(req_kind_t kind, int x, int y, int off, int g, int c, int ord);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, ORDER_W'(ord), COLOR_W'(c), GLYPH_W'(g), COORD_W'(off),
                  COORD_W'(y), COORD_W'(x)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Unused fields of a read carry random bits; the block must ignore them.
  task automatic read_cell(int col, int row);
    issue(REQ_READ, col, row, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Pick a recently drawn cell half of the time, otherwise a spot on or just off screen.
  task automatic read_somewhere();
    int pick;
    if (drawn_col.size() != 0 && $urandom_range(1) == 0) begin
      pick = $urandom_range(drawn_col.size() - 1);
      read_cell(drawn_col[pick], drawn_row[pick]);
    end else begin
      read_cell(int'($urandom_range(screen_w + 3)) - 2, int'($urandom_range(screen_h + 3)) - 2);
    end
  endtask

  // Drop tvalid, wait for every read result, then let draws and any clear sweep finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Reconfigure the screen while idle; rows take only the low 7 bits of the write.
  task automatic set_screen(logic [CFG_DATA_W-1:0] cols_v, logic [CFG_DATA_W-1:0] rows_v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SCREEN_COLS;
    cfg_wdata <= cols_v;
    @(posedge clk);
    cfg_index <= REG_SCREEN_ROWS;
    cfg_wdata <= rows_v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    screen_w = (cols_v == 0) ? 1 : ((int'(cols_v) > MAX_COLS) ? MAX_COLS : int'(cols_v));
    screen_h = (rows_v[6:0] == 0) ? 1 :
               ((int'(rows_v[6:0]) > MAX_ROWS) ? MAX_ROWS : int'(rows_v[6:0]));
  endtask

  // Mostly whole strings drawn near the screen with reads of what they left behind;
  // the rest is random noise (including the unused code) and the odd clear.
  task automatic run_text(int n_items);
    int        done;
    int        r;
    int        len;
    int        col;
    int        row;
    int        off0;
    int        c;
    int        ord;
    req_kind_t kind;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(199);
      if (r < 130) begin
        len  = $urandom_range(1, 12);
        col  = int'($urandom_range(screen_w + 5)) - 4;
        row  = int'($urandom_range(screen_h + 1)) - 1;
        // Sometimes start deep into the string with the start column moved left.
        off0 = ($urandom_range(9) == 0) ? int'($urandom_range(2000)) : 0;
        // Narrow order range so ties and losing draws are common.
        ord  = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(6)) - 3;
        c    = $urandom;
        for (int k = 0; k < len; k++) begin
          issue(REQ_DRAW, col - off0, row, off0 + k, $urandom, c, ord);
          drawn_col.push_back(col + k);
          drawn_row.push_back(row);
          if (drawn_col.size() > 64) begin
            void'(drawn_col.pop_front());
            void'(drawn_row.pop_front());
          end
        end
        done += len;
      end else if (r < 180) begin
        read_somewhere();
        done++;
      end else if (r < 198) begin
        kind = req_kind_t'($urandom_range(1, 3));
        issue(kind, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (kind != REQ_NOP) done++;
      end else begin
        issue(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        done++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset screen of 80 x 25. The first transaction also waits
    // out the sweep of the whole store that follows reset.
    read_cell(0, 0);
    // Lowest order loses against the empty cell order of -1.
    issue(REQ_DRAW, 0, 0, 0, 'h41, 'h1234, 'h8000);
    read_cell(0, 0);
    // Equal order overwrites.
    issue(REQ_DRAW, 0, 0, 0, 'h42, 'h5678, 'hFFFF);
    // Negative start column brought on screen by the offset, highest order.
    issue(REQ_DRAW, -3, 0, 5, 'hFF, 'hFFFF, 'h7FFF);
    issue(REQ_DRAW, 2, 0, 0, 'h00, 'h0000, 'h7FFE);
    read_cell(2, 0);
    issue(REQ_DRAW, 79, 24, 0, 'h7E, 'hA5A5, 'h0000);
    // Clipped draws: right edge, bottom edge, far corners, left edge.
    issue(REQ_DRAW, 80, 0, 0, 'h01, 'h0001, 'h7FFF);
    issue(REQ_DRAW, 0, 25, 0, 'h02, 'h0002, 'h7FFF);
    issue(REQ_DRAW, -2048, -2048, 4095, 'h03, 'h0003, 'h7FFF);
    issue(REQ_DRAW, 2047, 2047, 4095, 'h04, 'h0004, 'h7FFF);
    issue(REQ_DRAW, -1, 0, 0, 'h05, 'h0005, 'h7FFF);
    read_cell(79, 24);
    // Off-screen reads return zeros with in_range clear.
    read_cell(80, 0);
    read_cell(-1, 0);
    read_cell(0, -2048);
    read_cell(2047, 2047);
    // Unused request code must leave the store alone.
    issue(REQ_NOP, -1, -1, -1, -1, -1, -1);
    read_cell(0, 0);
    issue(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    read_cell(2, 0);
    read_cell(79, 24);

    // Random phases. Sender idles less than receiver first.
    set_screen(8'd1, 8'd1);
    run_text(40);
    set_screen(8'd128, 8'd64);
    run_text(100);
    // Zero registers count as one; clear only cell 0 so the rest survives.
    set_screen(8'd0, 8'd0);
    run_text(100);

    // Swap idle rates: sender idles more than receiver.
    tx_idle_pct = 55;
    rx_idle_pct = 24;
    // Over-range values clamp to the full store; earlier large-screen drawings remain.
    set_screen(8'd255, 8'd255);
    run_text(100);
    set_screen(8'd13, 8'd7);
    // Long receiver hold-off while reads keep coming, until input backs up.
    rx_hold_req <= 1'b1;
    repeat (60) read_somewhere();
    run_text(100);
    set_screen(8'd37, 8'd2);
    run_text(100);

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_screen(8'($urandom_range(1, MAX_COLS)), 8'($urandom_range(1, MAX_ROWS)));
    run_text(100);
    set_screen(8'($urandom_range(1, MAX_COLS)), 8'($urandom_range(1, MAX_ROWS)));
    run_text(100);

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
